>>> hdl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502 package
// opcode timing table, status bit positions and helpers for the execute unit
// ----------------------------------------------------------------------------
package c6502_pkg;

   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_D = 3;
   localparam int FL_B = 4;
   localparam int FL_U = 5;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   localparam logic [7:0] SP_RESET   = 8'hFD;
   localparam logic [7:0] P_RESET    = 8'h34;
   localparam logic [7:0] STACK_PAGE = 8'h01;

   localparam logic [3:0] BASE_CYCLES [0:255] = '{
      4'd7,4'd6,4'd2,4'd2,4'd2,4'd3,4'd5,4'd2,4'd3,4'd2,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2,
      4'd6,4'd6,4'd2,4'd2,4'd3,4'd3,4'd5,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2,
      4'd6,4'd6,4'd2,4'd2,4'd2,4'd3,4'd5,4'd2,4'd3,4'd2,4'd2,4'd2,4'd3,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2,
      4'd6,4'd6,4'd2,4'd2,4'd2,4'd3,4'd5,4'd2,4'd4,4'd2,4'd2,4'd2,4'd5,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2,
      4'd2,4'd6,4'd2,4'd2,4'd3,4'd3,4'd3,4'd2,4'd2,4'd2,4'd2,4'd2,4'd4,4'd4,4'd4,4'd2,
      4'd2,4'd6,4'd2,4'd2,4'd4,4'd4,4'd4,4'd2,4'd2,4'd5,4'd2,4'd2,4'd2,4'd5,4'd2,4'd2,
      4'd2,4'd6,4'd2,4'd2,4'd3,4'd3,4'd3,4'd2,4'd2,4'd2,4'd2,4'd2,4'd4,4'd4,4'd4,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd4,4'd4,4'd4,4'd2,4'd2,4'd4,4'd2,4'd2,4'd4,4'd4,4'd4,4'd2,
      4'd2,4'd6,4'd2,4'd2,4'd3,4'd3,4'd5,4'd2,4'd2,4'd2,4'd2,4'd2,4'd4,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2,
      4'd2,4'd6,4'd2,4'd2,4'd3,4'd3,4'd5,4'd2,4'd2,4'd2,4'd2,4'd2,4'd4,4'd4,4'd6,4'd2,
      4'd2,4'd5,4'd2,4'd2,4'd2,4'd4,4'd6,4'd2,4'd2,4'd4,4'd2,4'd2,4'd2,4'd4,4'd7,4'd2
   };

   // reading instructions in indexed modes that pay for a page crossing
   function automatic logic page_penalty(input logic [7:0] op);
      logic [4:0] lo;
      logic       res;
      lo = op[4:0];
      if (op[1:0] == 2'b01 && op != 8'h91 && op != 8'h99 && op != 8'h9D) begin
         res = (lo == 5'h11) || (lo == 5'h19) || (lo == 5'h1D);
      end else begin
         res = (op == 8'hBC) || (op == 8'hBE);
      end
      return res;
   endfunction

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[FL_N] = v[7];
      q[FL_Z] = (v == 8'h00);
      return q;
   endfunction

endpackage

>>> hdl/cpu_6502_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu_6502_execute_unit
// executes one official 6502 instruction per request, binary arithmetic only
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction: opcode, operand byte, effective address,
//   next pc, page-cross flag, the three stack bytes above sp and the brk
//   vector. A request is taken at a clock edge with req_valid high and
//   req_stall low.
//   rsp_* returns one result per memory write in bus order (one to three),
//   or a single result with no write. The last result of a request carries
//   the register snapshot and rsp_cycle_count.
//   Flow: a request is registered in the input register at acceptance,
//   executed combinationally from there, and moves into the result buffer,
//   which drives rsp_*, once the buffer is empty or drains its last result.
//   Throughput: one request per cycle for instructions with at most one
//   write while rsp_stall is low; a request with n writes holds the result
//   buffer until all n have drained, one write per cycle while not stalled.
//   Reset: A, X, Y cleared, sp = 0xFD, status = 0x34; both stages empty.
//   When the receiver stalls, the result holds; the input register still
//   takes one request and then req_stall rises until the buffer frees up.
// ----------------------------------------------------------------------------
module cpu_6502_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_operation,
   input  logic [7:0]  req_operand_data,
   input  logic [15:0] req_effective_address,
   input  logic [15:0] req_next_pc,
   input  logic        req_page_crossed,
   input  logic [7:0]  req_stack_byte_1,
   input  logic [7:0]  req_stack_byte_2,
   input  logic [7:0]  req_stack_byte_3,
   input  logic [15:0] req_break_vector,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_last,
   output logic [15:0] rsp_program_counter,
   output logic [7:0]  rsp_accumulator_out,
   output logic [7:0]  rsp_x_out,
   output logic [7:0]  rsp_y_out,
   output logic [7:0]  rsp_stack_pointer_out,
   output logic [7:0]  rsp_status_out,
   output logic [3:0]  rsp_cycle_count
);
   import c6502_pkg::*;

   // architectural registers
   logic [7:0] a_ff, x_ff, y_ff, sp_ff, p_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  op_ff, m_ff, s1_ff, s2_ff, s3_ff;
   logic [15:0] ea_ff, npc_ff, bvec_ff;
   logic        px_ff;

   // result buffer
   logic        out_valid_ff;
   logic [1:0]  out_idx_ff, out_cnt_ff;
   logic        out_wr_ff;
   logic [15:0] wa_ff [3];
   logic [7:0]  wd_ff [3];
   logic [15:0] pc_ff;
   logic [7:0]  ra_ff, rx_ff, ry_ff, rsp_sp_ff, rp_ff;
   logic [3:0]  cyc_ff;

   // execute results
   logic [7:0]  a_in, x_in, y_in, sp_in, p_in;
   logic [15:0] pc_in;
   logic [3:0]  cyc_in;
   logic [1:0]  wcnt_in;
   logic [15:0] wa_in [3];
   logic [7:0]  wd_in [3];

   logic out_last;
   logic move;

   assign out_last  = (out_idx_ff == out_cnt_ff - 2'd1);
   // the executed request moves into the buffer when it is empty or drains now
   assign move      = in_valid_ff && (!out_valid_ff || (!rsp_stall && out_last));
   assign req_stall = in_valid_ff && !move;

   // execute: one instruction against the current register file
   always_comb begin
      logic [7:0]  a, x, y, sp, p, v, r, mm;
      logic [8:0]  sum;
      logic [15:0] ret;
      logic        br, br_taken, cin;
      a = a_ff; x = x_ff; y = y_ff; sp = sp_ff; p = p_ff;
      pc_in = npc_ff;
      cyc_in = BASE_CYCLES[op_ff] + {3'd0, page_penalty(op_ff) & px_ff};
      wcnt_in = 2'd0;
      for (int i = 0; i < 3; i++) begin
         wa_in[i] = 16'h0000;
         wd_in[i] = 8'h00;
      end
      br = 1'b0; br_taken = 1'b0;
      v = 8'h00; r = 8'h00; sum = 9'h000; ret = 16'h0000;
      mm = m_ff;
      cin = p[FL_C];
      if (op_ff[1:0] == 2'b01 && op_ff != 8'h89) begin
         // group one alu ops
         unique case (op_ff[7:5])
            3'd0: begin a = a | m_ff; p = set_nz(p, a); end
            3'd1: begin a = a & m_ff; p = set_nz(p, a); end
            3'd2: begin a = a ^ m_ff; p = set_nz(p, a); end
            3'd4: begin wa_in[0] = ea_ff; wd_in[0] = a; wcnt_in = 2'd1; end
            3'd5: begin a = m_ff; p = set_nz(p, a); end
            3'd6: begin
               p[FL_C] = (a >= m_ff);
               p = set_nz(p, a - m_ff);
            end
            default: begin
               // adc, sbc is adc of the inverted operand
               if (op_ff[7:5] == 3'd7) mm = ~m_ff;
               sum = {1'b0, a} + {1'b0, mm} + {8'd0, cin};
               r = sum[7:0];
               p[FL_C] = sum[8];
               p[FL_V] = ~(a[7] ^ mm[7]) & (a[7] ^ r[7]);
               a = r;
               p = set_nz(p, a);
            end
         endcase
      end else begin
         unique case (op_ff)
            8'h06, 8'h0E, 8'h16, 8'h1E, 8'h0A,
            8'h26, 8'h2E, 8'h36, 8'h3E, 8'h2A,
            8'h46, 8'h4E, 8'h56, 8'h5E, 8'h4A,
            8'h66, 8'h6E, 8'h76, 8'h7E, 8'h6A: begin
               v = (op_ff[3:0] == 4'hA) ? a : m_ff;
               unique case (op_ff[6:5])
                  2'd0: begin r = {v[6:0], 1'b0}; p[FL_C] = v[7]; end
                  2'd1: begin r = {v[6:0], cin};  p[FL_C] = v[7]; end
                  2'd2: begin r = {1'b0, v[7:1]}; p[FL_C] = v[0]; end
                  default: begin r = {cin, v[7:1]}; p[FL_C] = v[0]; end
               endcase
               p = set_nz(p, r);
               if (op_ff[3:0] == 4'hA) begin
                  a = r;
               end else begin
                  wa_in[0] = ea_ff; wd_in[0] = r; wcnt_in = 2'd1;
               end
            end
            8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
               r = m_ff + 8'd1; p = set_nz(p, r);
               wa_in[0] = ea_ff; wd_in[0] = r; wcnt_in = 2'd1;
            end
            8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
               r = m_ff - 8'd1; p = set_nz(p, r);
               wa_in[0] = ea_ff; wd_in[0] = r; wcnt_in = 2'd1;
            end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin x = m_ff; p = set_nz(p, x); end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin y = m_ff; p = set_nz(p, y); end
            8'h86, 8'h8E, 8'h96: begin
               wa_in[0] = ea_ff; wd_in[0] = x; wcnt_in = 2'd1;
            end
            8'h84, 8'h8C, 8'h94: begin
               wa_in[0] = ea_ff; wd_in[0] = y; wcnt_in = 2'd1;
            end
            8'hE0, 8'hE4, 8'hEC: begin p[FL_C] = (x >= m_ff); p = set_nz(p, x - m_ff); end
            8'hC0, 8'hC4, 8'hCC: begin p[FL_C] = (y >= m_ff); p = set_nz(p, y - m_ff); end
            8'h24, 8'h2C: begin
               p[FL_N] = m_ff[7];
               p[FL_V] = m_ff[6];
               p[FL_Z] = ((a & m_ff) == 8'h00);
            end
            8'hAA: begin x = a;  p = set_nz(p, x); end
            8'hA8: begin y = a;  p = set_nz(p, y); end
            8'hBA: begin x = sp; p = set_nz(p, x); end
            8'h8A: begin a = x;  p = set_nz(p, a); end
            8'h9A: sp = x;
            8'h98: begin a = y;  p = set_nz(p, a); end
            8'hE8: begin x = x + 8'd1; p = set_nz(p, x); end
            8'hC8: begin y = y + 8'd1; p = set_nz(p, y); end
            8'hCA: begin x = x - 8'd1; p = set_nz(p, x); end
            8'h88: begin y = y - 8'd1; p = set_nz(p, y); end
            8'h48: begin
               wa_in[0] = {STACK_PAGE, sp}; wd_in[0] = a; wcnt_in = 2'd1;
               sp = sp - 8'd1;
            end
            8'h08: begin
               wa_in[0] = {STACK_PAGE, sp}; wd_in[0] = p | 8'h30; wcnt_in = 2'd1;
               sp = sp - 8'd1;
            end
            8'h68: begin sp = sp + 8'd1; a = s1_ff; p = set_nz(p, a); end
            8'h28: begin sp = sp + 8'd1; p = s1_ff | 8'h30; end
            8'h4C, 8'h6C: pc_in = ea_ff;
            8'h20: begin
               ret = npc_ff - 16'd1;
               wa_in[0] = {STACK_PAGE, sp};         wd_in[0] = ret[15:8];
               wa_in[1] = {STACK_PAGE, sp - 8'd1};  wd_in[1] = ret[7:0];
               wcnt_in = 2'd2;
               sp = sp - 8'd2;
               pc_in = ea_ff;
            end
            8'h60: begin
               sp = sp + 8'd2;
               pc_in = {s2_ff, s1_ff} + 16'd1;
            end
            8'h40: begin
               sp = sp + 8'd3;
               p = s1_ff | 8'h30;
               pc_in = {s3_ff, s2_ff};
            end
            8'h00: begin
               ret = npc_ff + 16'd1;
               wa_in[0] = {STACK_PAGE, sp};         wd_in[0] = ret[15:8];
               wa_in[1] = {STACK_PAGE, sp - 8'd1};  wd_in[1] = ret[7:0];
               wa_in[2] = {STACK_PAGE, sp - 8'd2};  wd_in[2] = p | 8'h30;
               wcnt_in = 2'd3;
               sp = sp - 8'd3;
               p[FL_I] = 1'b1;
               pc_in = bvec_ff;
            end
            8'h10: begin br = 1'b1; br_taken = !p[FL_N]; end
            8'h30: begin br = 1'b1; br_taken =  p[FL_N]; end
            8'h50: begin br = 1'b1; br_taken = !p[FL_V]; end
            8'h70: begin br = 1'b1; br_taken =  p[FL_V]; end
            8'h90: begin br = 1'b1; br_taken = !p[FL_C]; end
            8'hB0: begin br = 1'b1; br_taken =  p[FL_C]; end
            8'hD0: begin br = 1'b1; br_taken = !p[FL_Z]; end
            8'hF0: begin br = 1'b1; br_taken =  p[FL_Z]; end
            8'h18: p[FL_C] = 1'b0;
            8'h38: p[FL_C] = 1'b1;
            8'h58: p[FL_I] = 1'b0;
            8'h78: p[FL_I] = 1'b1;
            8'hB8: p[FL_V] = 1'b0;
            8'hD8: p[FL_D] = 1'b0;
            8'hF8: p[FL_D] = 1'b1;
            default: ;
         endcase
      end
      // taken branch: pc takes ea; the cycle count adds the taken penalty and, on a page crossing, the page penalty
      if (br && br_taken) begin
         pc_in = ea_ff;
         cyc_in = cyc_in + 4'd1 + {3'd0, px_ff};
      end
      a_in = a; x_in = x; y_in = y; sp_in = sp; p_in = p;
   end

   // architectural state commits when the request leaves the execute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= 8'h00;
         x_ff  <= 8'h00;
         y_ff  <= 8'h00;
         sp_ff <= SP_RESET;
         p_ff  <= P_RESET;
      end else if (move) begin
         a_ff  <= a_in;
         x_ff  <= x_in;
         y_ff  <= y_in;
         sp_ff <= sp_in;
         p_ff  <= p_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff   <= req_operation;
         m_ff    <= req_operand_data;
         ea_ff   <= req_effective_address;
         npc_ff  <= req_next_pc;
         px_ff   <= req_page_crossed;
         s1_ff   <= req_stack_byte_1;
         s2_ff   <= req_stack_byte_2;
         s3_ff   <= req_stack_byte_3;
         bvec_ff <= req_break_vector;
      end
   end

   // result buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_idx_ff   <= 2'd0;
         out_cnt_ff   <= 2'd1;
      end else if (move) begin
         out_valid_ff <= 1'b1;
         out_idx_ff   <= 2'd0;
         out_cnt_ff   <= (wcnt_in == 2'd0) ? 2'd1 : wcnt_in;
      end else if (out_valid_ff && !rsp_stall) begin
         if (out_last) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_idx_ff <= out_idx_ff + 2'd1;
         end
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (move) begin
         out_wr_ff <= (wcnt_in != 2'd0);
         for (int i = 0; i < 3; i++) begin
            wa_ff[i] <= wa_in[i];
            wd_ff[i] <= wd_in[i];
         end
         pc_ff     <= pc_in;
         ra_ff     <= a_in;
         rx_ff     <= x_in;
         ry_ff     <= y_in;
         rsp_sp_ff <= sp_in;
         rp_ff     <= p_in;
         cyc_ff    <= cyc_in;
      end
   end

   // result outputs: snapshot only on the last result
   always_comb begin
      rsp_valid             = out_valid_ff;
      rsp_write_valid       = out_wr_ff;
      rsp_write_address     = 16'h0000;
      rsp_write_data        = 8'h00;
      unique case (out_idx_ff)
         2'd0: begin rsp_write_address = wa_ff[0]; rsp_write_data = wd_ff[0]; end
         2'd1: begin rsp_write_address = wa_ff[1]; rsp_write_data = wd_ff[1]; end
         default: begin rsp_write_address = wa_ff[2]; rsp_write_data = wd_ff[2]; end
      endcase
      rsp_last              = out_last;
      rsp_program_counter   = out_last ? pc_ff     : 16'h0000;
      rsp_accumulator_out   = out_last ? ra_ff     : 8'h00;
      rsp_x_out             = out_last ? rx_ff     : 8'h00;
      rsp_y_out             = out_last ? ry_ff     : 8'h00;
      rsp_stack_pointer_out = out_last ? rsp_sp_ff : 8'h00;
      rsp_status_out        = out_last ? rp_ff     : 8'h00;
      rsp_cycle_count       = out_last ? cyc_ff    : 4'd0;
   end

`ifndef ASSERT_OFF
   // a result that is not the last one is always a memory write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_write_valid)
      else $error("non-final result without write");

   // the buffer never holds an empty instruction
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_cnt_ff != 2'd0 && out_idx_ff < out_cnt_ff)
      else $error("result index out of range");

   // input side only stalls while an instruction waits in execute
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("stall without pending instruction");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives random and directed 6502 instructions into the execute unit, predicts
// the memory writes and register snapshot of each, and checks every result
// ----------------------------------------------------------------------------
module tb_top;
   import c6502_pkg::*;

   typedef struct packed {
      logic [7:0]  op;
      logic [7:0]  m;
      logic [15:0] ea;
      logic [15:0] npc;
      logic        px;
      logic [7:0]  s1;
      logic [7:0]  s2;
      logic [7:0]  s3;
      logic [15:0] bvec;
   } instr_type;

   typedef struct packed {
      logic        wv;
      logic [15:0] wa;
      logic [7:0]  wd;
      logic        last;
      logic [15:0] pc;
      logic [7:0]  a;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  p;
      logic [3:0]  cyc;
   } bus_result_type;

   // flag masks
   localparam logic [7:0] M_C = 8'h01, M_Z = 8'h02, M_I = 8'h04, M_D = 8'h08;
   localparam logic [7:0] M_B = 8'h10, M_U = 8'h20, M_V = 8'h40, M_N = 8'h80;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   instr_type cur = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wire bus_result_type got;

   instr_type      pending_instrs[$];
   bus_result_type expected_results[$];
   int             mismatch_count = 0;
   int             cycle_count_tb = 0;

   // request on the bus was taken at the last rising edge
   logic in_taken = 1'b0;

   // idling phase: 0 none, 1 sender, 2 receiver, 3 both
   int  idle_mode = 0;
   int  hold_off = 0;
   logic all_sent = 1'b0;

   // predictor state
   logic [7:0] ra, rx, ry, rsp_ptr, rp;

   cpu_6502_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(cur.op), .req_operand_data(cur.m),
      .req_effective_address(cur.ea), .req_next_pc(cur.npc),
      .req_page_crossed(cur.px), .req_stack_byte_1(cur.s1),
      .req_stack_byte_2(cur.s2), .req_stack_byte_3(cur.s3),
      .req_break_vector(cur.bvec),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_write_valid(got.wv), .rsp_write_address(got.wa),
      .rsp_write_data(got.wd), .rsp_last(got.last),
      .rsp_program_counter(got.pc), .rsp_accumulator_out(got.a),
      .rsp_x_out(got.x), .rsp_y_out(got.y),
      .rsp_stack_pointer_out(got.sp), .rsp_status_out(got.p),
      .rsp_cycle_count(got.cyc)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
      return (p & ~(M_N | M_Z)) | (v & M_N) | ((v == 8'h00) ? M_Z : 8'h00);
   endfunction

   function automatic logic penalty_op(input logic [7:0] op);
      if (op[1:0] == 2'b01 && op != 8'h91 && op != 8'h99 && op != 8'h9D)
         return (op[4:0] == 5'h11) || (op[4:0] == 5'h19) || (op[4:0] == 5'h1D);
      return (op == 8'hBC) || (op == 8'hBE);
   endfunction

   task automatic execute_instr(input instr_type it);
      logic [15:0] wa[3];
      logic [7:0]  wd[3];
      int          nw;
      logic [15:0] pc;
      logic [3:0]  cyc;
      logic        taken;
      logic [7:0]  v, r, mm;
      logic [8:0]  sum;
      logic        cin;
      logic [15:0] ret;
      bus_result_type e;
      nw = 0; pc = it.npc; cyc = BASE_CYCLES[it.op]; taken = 1'b0;
      if (penalty_op(it.op)) cyc = cyc + {3'd0, it.px};
      if (it.op[1:0] == 2'b01 && it.op != 8'h89) begin
         case (it.op[7:5])
            3'd0: begin ra = ra | it.m; rp = nz(rp, ra); end
            3'd1: begin ra = ra & it.m; rp = nz(rp, ra); end
            3'd2: begin ra = ra ^ it.m; rp = nz(rp, ra); end
            3'd4: begin wa[nw] = it.ea; wd[nw] = ra; nw++; end
            3'd5: begin ra = it.m; rp = nz(rp, ra); end
            3'd6: begin
               rp[0] = (ra >= it.m); rp = nz(rp, ra - it.m);
            end
            default: begin
               // adc, and sbc as adc of the inverted operand
               mm = (it.op[7:5] == 3'd3) ? it.m : ~it.m;
               sum = {1'b0, ra} + {1'b0, mm} + {8'd0, rp[0]};
               r = sum[7:0];
               rp[0] = sum[8];
               rp[6] = (~(ra ^ mm) & (ra ^ r) & 8'h80) != 8'h00;
               ra = r; rp = nz(rp, r);
            end
         endcase
      end else begin
         case (it.op)
            8'h06, 8'h0E, 8'h16, 8'h1E, 8'h0A, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h2A,
            8'h46, 8'h4E, 8'h56, 8'h5E, 8'h4A, 8'h66, 8'h6E, 8'h76, 8'h7E,
            8'h6A: begin
               cin = rp[0];
               v = (it.op[3:0] == 4'hA) ? ra : it.m;
               case (it.op[7:5])
                  3'd0: begin r = {v[6:0], 1'b0}; rp[0] = v[7]; end
                  3'd1: begin r = {v[6:0], cin}; rp[0] = v[7]; end
                  3'd2: begin r = {1'b0, v[7:1]}; rp[0] = v[0]; end
                  default: begin r = {cin, v[7:1]}; rp[0] = v[0]; end
               endcase
               rp = nz(rp, r);
               if (it.op[3:0] == 4'hA) ra = r;
               else begin wa[nw] = it.ea; wd[nw] = r; nw++; end
            end
            8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
               r = it.m + 8'd1; rp = nz(rp, r); wa[nw] = it.ea; wd[nw] = r; nw++;
            end
            8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
               r = it.m - 8'd1; rp = nz(rp, r); wa[nw] = it.ea; wd[nw] = r; nw++;
            end
            8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin rx = it.m; rp = nz(rp, rx); end
            8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin ry = it.m; rp = nz(rp, ry); end
            8'h86, 8'h8E, 8'h96: begin wa[nw] = it.ea; wd[nw] = rx; nw++; end
            8'h84, 8'h8C, 8'h94: begin wa[nw] = it.ea; wd[nw] = ry; nw++; end
            8'hE0, 8'hE4, 8'hEC: begin rp[0] = (rx >= it.m); rp = nz(rp, rx - it.m); end
            8'hC0, 8'hC4, 8'hCC: begin rp[0] = (ry >= it.m); rp = nz(rp, ry - it.m); end
            8'h24, 8'h2C:
               rp = (rp & 8'h3D) | (it.m & 8'hC0) | (((ra & it.m) == 8'h00) ? M_Z : 8'h00);
            8'hAA: begin rx = ra; rp = nz(rp, rx); end
            8'hA8: begin ry = ra; rp = nz(rp, ry); end
            8'hBA: begin rx = rsp_ptr; rp = nz(rp, rx); end
            8'h8A: begin ra = rx; rp = nz(rp, ra); end
            8'h9A: rsp_ptr = rx;
            8'h98: begin ra = ry; rp = nz(rp, ra); end
            8'hE8: begin rx = rx + 8'd1; rp = nz(rp, rx); end
            8'hC8: begin ry = ry + 8'd1; rp = nz(rp, ry); end
            8'hCA: begin rx = rx - 8'd1; rp = nz(rp, rx); end
            8'h88: begin ry = ry - 8'd1; rp = nz(rp, ry); end
            8'h48: begin
               wa[nw] = {8'h01, rsp_ptr}; wd[nw] = ra; nw++; rsp_ptr = rsp_ptr - 8'd1;
            end
            8'h08: begin
               wa[nw] = {8'h01, rsp_ptr}; wd[nw] = rp | M_B | M_U; nw++;
               rsp_ptr = rsp_ptr - 8'd1;
            end
            8'h68: begin rsp_ptr = rsp_ptr + 8'd1; ra = it.s1; rp = nz(rp, ra); end
            8'h28: begin rsp_ptr = rsp_ptr + 8'd1; rp = it.s1 | M_B | M_U; end
            8'h4C, 8'h6C: pc = it.ea;
            8'h20, 8'h00: begin
               // jsr pushes pc-1, brk pushes pc+1 and the flags
               ret = (it.op == 8'h20) ? it.npc - 16'd1 : it.npc + 16'd1;
               wa[nw] = {8'h01, rsp_ptr}; wd[nw] = ret[15:8]; nw++;
               rsp_ptr = rsp_ptr - 8'd1;
               wa[nw] = {8'h01, rsp_ptr}; wd[nw] = ret[7:0]; nw++;
               rsp_ptr = rsp_ptr - 8'd1;
               if (it.op == 8'h00) begin
                  wa[nw] = {8'h01, rsp_ptr}; wd[nw] = rp | M_B | M_U; nw++;
                  rsp_ptr = rsp_ptr - 8'd1;
                  rp = rp | M_I;
                  pc = it.bvec;
               end else pc = it.ea;
            end
            8'h60: begin rsp_ptr = rsp_ptr + 8'd2; pc = {it.s2, it.s1} + 16'd1; end
            8'h40: begin
               rsp_ptr = rsp_ptr + 8'd3; rp = it.s1 | M_B | M_U; pc = {it.s3, it.s2};
            end
            8'h10: taken = !rp[7];
            8'h30: taken = rp[7];
            8'h50: taken = !rp[6];
            8'h70: taken = rp[6];
            8'h90: taken = !rp[0];
            8'hB0: taken = rp[0];
            8'hD0: taken = !rp[1];
            8'hF0: taken = rp[1];
            8'h18: rp = rp & ~M_C;
            8'h38: rp = rp | M_C;
            8'h58: rp = rp & ~M_I;
            8'h78: rp = rp | M_I;
            8'hB8: rp = rp & ~M_V;
            8'hD8: rp = rp & ~M_D;
            8'hF8: rp = rp | M_D;
            default: ;
         endcase
      end
      if (taken) begin pc = it.ea; cyc = cyc + 4'd1 + {3'd0, it.px}; end
      for (int k = 0; k < ((nw == 0) ? 1 : nw); k++) begin
         e = '0;
         if (k < nw) begin e.wv = 1'b1; e.wa = wa[k]; e.wd = wd[k]; end
         if (k == ((nw == 0) ? 0 : nw - 1)) begin
            e.last = 1'b1; e.pc = pc; e.a = ra; e.x = rx; e.y = ry;
            e.sp = rsp_ptr; e.p = rp; e.cyc = cyc;
         end
         expected_results.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
      $display("mismatch at cycle %0d: %s expected %0h got %0h",
               cycle_count_tb, what, exp_v, got_v);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- driver
   // a request is predicted at the edge it is accepted, which keeps the
   // prediction in acceptance order
   always @(posedge clock) begin
      in_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         execute_instr(cur);
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || in_taken)) begin
         // previous request was taken or nothing was offered
         if (pending_instrs.size() > 0 &&
             !((idle_mode == 1 || idle_mode == 3) && $urandom_range(99) < 76)) begin
            cur <= pending_instrs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_mode >= 2) && ($urandom_range(99) < 76);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      bus_result_type e;
      cycle_count_tb <= cycle_count_tb + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 0, got.wa);
         end else begin
            e = expected_results.pop_front();
            if (got.wv !== e.wv) report_mismatch("write_valid", e.wv, got.wv);
            if (got.wa !== e.wa) report_mismatch("write_address", e.wa, got.wa);
            if (got.wd !== e.wd) report_mismatch("write_data", e.wd, got.wd);
            if (got.last !== e.last) report_mismatch("last", e.last, got.last);
            if (got.pc !== e.pc) report_mismatch("program_counter", e.pc, got.pc);
            if (got.a !== e.a) report_mismatch("accumulator", e.a, got.a);
            if (got.x !== e.x) report_mismatch("x", e.x, got.x);
            if (got.y !== e.y) report_mismatch("y", e.y, got.y);
            if (got.sp !== e.sp) report_mismatch("stack_pointer", e.sp, got.sp);
            if (got.p !== e.p) report_mismatch("status", e.p, got.p);
            if (got.cyc !== e.cyc) report_mismatch("cycle_count", e.cyc, got.cyc);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count_tb > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic instr_type rand_instr(input logic [7:0] op);
      instr_type it;
      it.op = op; it.m = 8'($urandom); it.ea = 16'($urandom); it.npc = 16'($urandom);
      it.px = 1'($urandom); it.s1 = 8'($urandom); it.s2 = 8'($urandom);
      it.s3 = 8'($urandom);
      it.bvec = 16'($urandom);
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_instrs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      instr_type it;
      logic [7:0] dir_ops[$];
      ra = 8'h00; rx = 8'h00; ry = 8'h00; rsp_ptr = SP_RESET; rp = P_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: extremes, adc/sbc with carry out, rotates, stack ops, brk, rti,
      // branches with page cross set, unlisted opcode
      dir_ops = '{8'hA9, 8'h69, 8'hE9, 8'hA2, 8'hE8, 8'h9A, 8'h48, 8'h08, 8'h28,
                  8'h68, 8'h6A, 8'h2A, 8'h20, 8'h60, 8'h00, 8'h40, 8'h30, 8'hD0,
                  8'h7D, 8'hB1, 8'hBE, 8'h02, 8'hFE, 8'h24, 8'h6C};
      foreach (dir_ops[i]) begin
         it = rand_instr(dir_ops[i]);
         if (i < 2) begin it.m = 8'hFF; it.ea = 16'hFFFF; it.npc = 16'h0000; end
         if (i == 2) begin it.m = 8'h80; it.npc = 16'hFFFF; end
         if (dir_ops[i] == 8'hA2) it.m = 8'h00;
         if (dir_ops[i] == 8'h00) it.npc = 16'hFFFF;
         if (dir_ops[i] == 8'h28) it.s1 = 8'h00;
         if (dir_ops[i] == 8'h30 || dir_ops[i] == 8'hD0) it.px = 1'b1;
         pending_instrs.push_back(it);
      end
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         idle_mode = ph;
         for (int n = 0; n < 40; n++) pending_instrs.push_back(rand_instr(8'($urandom)));
         if (ph == 1) begin
            // long receiver hold-off while the sender offers with random pauses
            @(negedge clock) hold_off = 60;
         end
         wait_drained();
         // sender pauses here after every result has come
         repeat (4) @(posedge clock);
      end
      idle_mode = 0;
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/c6502_pkg.sv
hdl/cpu_6502_execute_unit.sv
sim/tb_top.sv
